/* src/lfdc_pkg.sv */
// Shared types and constants for the line follower drive control block.
// Depends on nothing; used by every module under src.
`default_nettype none

package lfdc_pkg;

    // Motor drive codes
    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_REV  = 2'd2;

    // Remote command characters (uppercase ASCII)
    localparam logic [7:0] CMD_F = 8'h46;
    localparam logic [7:0] CMD_B = 8'h42;
    localparam logic [7:0] CMD_R = 8'h52;
    localparam logic [7:0] CMD_L = 8'h4C;
    localparam logic [7:0] CMD_S = 8'h53;
    localparam logic [7:0] CMD_G = 8'h47;
    localparam logic [7:0] CMD_I = 8'h49;
    localparam logic [7:0] CMD_H = 8'h48;
    localparam logic [7:0] CMD_J = 8'h4A;

    // Line sensor patterns {front, right, left}, right and left already inverted
    localparam logic [2:0] PAT_ALL    = 3'b111;
    localparam logic [2:0] PAT_FRONT  = 3'b100;
    localparam logic [2:0] PAT_FR     = 3'b110;
    localparam logic [2:0] PAT_FL     = 3'b101;
    localparam logic [2:0] PAT_RIGHT  = 3'b010;
    localparam logic [2:0] PAT_LEFT   = 3'b001;

    // Configuration register indexes and reset values
    localparam int          CFG_ADDR_W = 4;
    localparam logic [1:0]  REG_NEAR    = 2'd0;
    localparam logic [1:0]  REG_LIMIT   = 2'd1;
    localparam logic [1:0]  REG_ADVANCE = 2'd2;
    localparam logic [15:0] NEAR_RST    = 16'd4372;
    localparam logic [15:0] LIMIT_RST   = 16'd3000;
    localparam logic [15:0] ADVANCE_RST = 16'd2000;

    typedef struct packed {
        logic [15:0] near_width_us;
        logic [15:0] search_limit_ms;
        logic [15:0] advance_ms;
    } t_cfg;

    typedef struct packed {
        logic        front_line;
        logic        right_raw;
        logic        left_raw;
        logic        remote_mode;
        logic        byte_valid;
        logic [7:0]  command_byte;
        logic [15:0] echo_width_us;
        logic [7:0]  step_ms;
    } t_item;

    typedef struct packed {
        logic [1:0]  right_last;
        logic [1:0]  left_last;
        logic        search_active;
        logic [15:0] search_elapsed;
        logic [15:0] hold_remaining;
    } t_state;

    typedef struct packed {
        logic [1:0] right_drive;
        logic [1:0] left_drive;
        logic       advancing;
    } t_result;

endpackage

`default_nettype wire

/* src/lfdc_cfg_regs.sv */
// APB-style configuration registers: near width, search limit, advance time.
// Depends on lfdc_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module lfdc_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lfdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output lfdc_pkg::t_cfg                       o_cfg
);

    lfdc_pkg::t_cfg r_cfg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_width_us   <= lfdc_pkg::NEAR_RST;
            r_cfg.search_limit_ms <= lfdc_pkg::LIMIT_RST;
            r_cfg.advance_ms      <= lfdc_pkg::ADVANCE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                lfdc_pkg::REG_NEAR:    r_cfg.near_width_us   <= pwdata[15:0];
                lfdc_pkg::REG_LIMIT:   r_cfg.search_limit_ms <= pwdata[15:0];
                lfdc_pkg::REG_ADVANCE: r_cfg.advance_ms      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lfdc_pkg::REG_NEAR:    prdata = {16'd0, r_cfg.near_width_us};
            lfdc_pkg::REG_LIMIT:   prdata = {16'd0, r_cfg.search_limit_ms};
            lfdc_pkg::REG_ADVANCE: prdata = {16'd0, r_cfg.advance_ms};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* src/lfdc_step.sv */
// Combinational control step: escape hold, remote decode, line follow, search.
// Depends on lfdc_pkg for drive codes, command characters and structs.
`default_nettype none

module lfdc_step (
    input  lfdc_pkg::t_item   i_item,
    input  lfdc_pkg::t_cfg    i_cfg,
    input  lfdc_pkg::t_state  i_state,
    output lfdc_pkg::t_state  o_state,
    output lfdc_pkg::t_result o_result
);

    logic [15:0] hold_dec;
    logic [16:0] elapsed_sum;
    logic [15:0] elapsed_new;
    logic [2:0]  pattern;
    logic        near;
    logic [1:0]  rd;
    logic [1:0]  ld;
    logic        adv;

    assign hold_dec = (i_state.hold_remaining > {8'd0, i_item.step_ms})
                    ? i_state.hold_remaining - {8'd0, i_item.step_ms} : 16'd0;
    assign elapsed_sum = {1'b0, i_state.search_elapsed} + {9'd0, i_item.step_ms};
    assign elapsed_new = !i_state.search_active ? 16'd0
                       : (elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0]);
    assign pattern = {i_item.front_line, ~i_item.right_raw, ~i_item.left_raw};
    assign near    = i_item.echo_width_us <= i_cfg.near_width_us;

    always_comb begin
        o_state                = i_state;
        o_state.hold_remaining = hold_dec;
        rd  = lfdc_pkg::DRV_STOP;
        ld  = lfdc_pkg::DRV_STOP;
        adv = 1'b0;
        priority if (hold_dec != 16'd0) begin
            // escape still running: ignore everything else
            rd  = lfdc_pkg::DRV_FWD;
            ld  = lfdc_pkg::DRV_FWD;
            adv = 1'b1;
        end else if (i_item.remote_mode) begin
            if (i_item.byte_valid) begin
                unique case (i_item.command_byte)
                    lfdc_pkg::CMD_F: begin rd = lfdc_pkg::DRV_FWD;  ld = lfdc_pkg::DRV_FWD;  end
                    lfdc_pkg::CMD_B: begin rd = lfdc_pkg::DRV_REV;  ld = lfdc_pkg::DRV_REV;  end
                    lfdc_pkg::CMD_R: begin rd = lfdc_pkg::DRV_REV;  ld = lfdc_pkg::DRV_FWD;  end
                    lfdc_pkg::CMD_L: begin rd = lfdc_pkg::DRV_FWD;  ld = lfdc_pkg::DRV_REV;  end
                    lfdc_pkg::CMD_G: begin rd = lfdc_pkg::DRV_FWD;  ld = lfdc_pkg::DRV_STOP; end
                    lfdc_pkg::CMD_I: begin rd = lfdc_pkg::DRV_STOP; ld = lfdc_pkg::DRV_FWD;  end
                    lfdc_pkg::CMD_H: begin rd = lfdc_pkg::DRV_REV;  ld = lfdc_pkg::DRV_STOP; end
                    lfdc_pkg::CMD_J: begin rd = lfdc_pkg::DRV_STOP; ld = lfdc_pkg::DRV_REV;  end
                    lfdc_pkg::CMD_S: begin rd = lfdc_pkg::DRV_STOP; ld = lfdc_pkg::DRV_STOP; end
                    default:         begin rd = lfdc_pkg::DRV_STOP; ld = lfdc_pkg::DRV_STOP; end
                endcase
            end
        end else if (near) begin
            o_state.search_active  = 1'b0;
            o_state.search_elapsed = 16'd0;
            unique case (pattern)
                lfdc_pkg::PAT_ALL,
                lfdc_pkg::PAT_FRONT: begin rd = lfdc_pkg::DRV_FWD;  ld = lfdc_pkg::DRV_FWD;  end
                lfdc_pkg::PAT_FR:    begin rd = lfdc_pkg::DRV_STOP; ld = lfdc_pkg::DRV_FWD;  end
                lfdc_pkg::PAT_FL:    begin rd = lfdc_pkg::DRV_FWD;  ld = lfdc_pkg::DRV_STOP; end
                lfdc_pkg::PAT_RIGHT: begin rd = lfdc_pkg::DRV_REV;  ld = lfdc_pkg::DRV_FWD;  end
                lfdc_pkg::PAT_LEFT:  begin rd = lfdc_pkg::DRV_FWD;  ld = lfdc_pkg::DRV_REV;  end
                default: begin
                    // no usable pattern: hold the last drive
                    rd = i_state.right_last;
                    ld = i_state.left_last;
                end
            endcase
        end else if (elapsed_new >= i_cfg.search_limit_ms) begin
            o_state.search_active  = 1'b0;
            o_state.search_elapsed = 16'd0;
            o_state.hold_remaining = i_cfg.advance_ms;
            rd  = lfdc_pkg::DRV_FWD;
            ld  = lfdc_pkg::DRV_FWD;
            adv = 1'b1;
        end else begin
            o_state.search_active  = 1'b1;
            o_state.search_elapsed = elapsed_new;
            rd = lfdc_pkg::DRV_FWD;
            ld = lfdc_pkg::DRV_REV;
        end
        o_state.right_last   = rd;
        o_state.left_last    = ld;
        o_result.right_drive = rd;
        o_result.left_drive  = ld;
        o_result.advancing   = adv;
    end

endmodule

`default_nettype wire

/* src/line_follower_drive_control.sv */
// Top level of the line follower drive control block.
// Depends on lfdc_pkg, lfdc_cfg_regs and lfdc_step.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one control step per item:
//   line sensors, remote-mode pin, optional command byte, echo width and the
//   milliseconds elapsed since the previous step. Output channel
//   (o_out_valid / i_out_stall) returns one drive item per input item:
//   right and left drive codes and the escape flag.
//   An accepted item lands in the input register; when the result register is
//   free it passes through the step logic into that register, which also
//   updates the controller state (last drive, search timer, escape hold). One
//   item per cycle is sustained while the receiver does not stall; the state
//   feedback through the step logic allows that. When the receiver stalls, the
//   result register holds; the input register keeps taking one item and then
//   stall is raised toward the sender. Synchronous active-low reset empties
//   both registers, sets the last drive to stop, clears the timers and
//   restores the configuration defaults. The user must write configuration
//   over the APB-style port only while the block is idle; it is not enforced.
`default_nettype none

module line_follower_drive_control (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lfdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_front_line,
    input  wire logic                            i_right_raw,
    input  wire logic                            i_left_raw,
    input  wire logic                            i_remote_mode,
    input  wire logic                            i_byte_valid,
    input  wire logic [7:0]                      i_command_byte,
    input  wire logic [15:0]                     i_echo_width_us,
    input  wire logic [7:0]                      i_step_ms,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [1:0]                      o_right_drive,
    output logic      [1:0]                      o_left_drive,
    output logic                                 o_advancing
);

    lfdc_pkg::t_cfg    cfg;
    lfdc_pkg::t_item   r_item;
    logic              r_in_vld;
    lfdc_pkg::t_state  r_state;
    lfdc_pkg::t_state  n_state;
    lfdc_pkg::t_result r_result;
    lfdc_pkg::t_result n_result;
    logic              r_out_vld;
    logic              advance;
    logic              take;

    lfdc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfdc_step u_step (
        .i_item   (r_item),
        .i_cfg    (cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Move the held item into the result register whenever that slot frees up.
    assign advance    = r_in_vld & (~r_out_vld | ~i_out_stall);
    // Stall the sender only while the input register is full and cannot drain.
    assign o_in_stall = r_in_vld & ~advance;
    assign take       = i_in_valid & ~o_in_stall;

    // Input register: control bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // Input register: payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.front_line    <= i_front_line;
            r_item.right_raw     <= i_right_raw;
            r_item.left_raw      <= i_left_raw;
            r_item.remote_mode   <= i_remote_mode;
            r_item.byte_valid    <= i_byte_valid;
            r_item.command_byte  <= i_command_byte;
            r_item.echo_width_us <= i_echo_width_us;
            r_item.step_ms       <= i_step_ms;
        end
    end

    // Controller state advances together with each item that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.right_last     <= lfdc_pkg::DRV_STOP;
            r_state.left_last      <= lfdc_pkg::DRV_STOP;
            r_state.search_active  <= 1'b0;
            r_state.search_elapsed <= 16'd0;
            r_state.hold_remaining <= 16'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: valid drops once the receiver takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (~i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_right_drive = r_result.right_drive;
    assign o_left_drive  = r_result.left_drive;
    assign o_advancing   = r_result.advancing;

endmodule

`default_nettype wire
